@@ hw/rtl/assert_macros.svh @@
// Assertion macros shared by the RTL of the speed supervision block.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

@@ hw/rtl/tssf_pkg.sv @@
// Package for the train speed supervision block: codes, state struct, widths.
// No dependencies; imported by tssf_step and train_speed_supervision_fsm.
`timescale 1ns / 1ps

package tssf_pkg;

	localparam int SpdW = 13;
	localparam logic [SpdW-1:0] ReleaseSpeedRst = 13'd640;
	// clears the sixteenths: whole km/h
	localparam logic [SpdW-1:0] FloorMask = 13'h1FF0;

	typedef logic [SpdW-1:0] speed_t;

	typedef enum logic [1:0] {
		MODE_CEILING = 2'd0,
		MODE_TARGET  = 2'd1,
		MODE_RELEASE = 2'd2
	} mode_t;

	typedef enum logic [2:0] {
		SUP_NORMAL       = 3'd0,
		SUP_INDICATION   = 3'd1,
		SUP_OVERSPEED    = 3'd2,
		SUP_WARNING      = 3'd3,
		SUP_INTERVENTION = 3'd4
	} sup_t;

	typedef enum logic [1:0] {
		TONE_NONE      = 2'd0,
		TONE_OVERSPEED = 2'd1,
		TONE_WARNING   = 2'd2
	} tone_t;

	typedef struct packed {
		mode_t mode;
		sup_t  sup;
		logic  brake;
		tone_t tone;
	} sup_state_t;

	typedef struct packed {
		speed_t train;
		speed_t limit;
		speed_t ind;
		speed_t perm;
		speed_t warn;
		speed_t ebi;
		logic   tgt_upd;
	} tick_t;

endpackage

@@ hw/rtl/tssf_step.sv @@
// One supervision tick: mode transitions, then status, brake latch and tone.
// Depends on tssf_pkg; instantiated by train_speed_supervision_fsm.
`timescale 1ns / 1ps

module tssf_step
	import tssf_pkg::*;
(
	input  sup_state_t cur,
	input  tick_t      tick,
	input  speed_t     release_speed,
	output sup_state_t nxt,
	output logic       chime
);

	logic  ind_ok;
	logic  rel;
	mode_t m;
	sup_t  s;
	logic  brake;
	tone_t tone;

	assign ind_ok = (tick.ind <= tick.limit) && (tick.train >= release_speed);
	assign rel    = tick.ebi <= release_speed;

	always_comb begin
		m     = cur.mode;
		s     = cur.sup;
		brake = cur.brake;
		tone  = cur.tone;
		chime = 1'b0;

		// mode transitions, each one sees the mode left by the previous
		if (m == MODE_CEILING && ind_ok) begin
			m     = MODE_TARGET;
			chime = 1'b1;
		end
		if ((m == MODE_CEILING || m == MODE_TARGET) && rel)
			m = MODE_RELEASE;
		if ((m == MODE_RELEASE || m == MODE_TARGET) && tick.tgt_upd && !ind_ok && !rel) begin
			m     = MODE_CEILING;
			chime = 1'b1;
		end
		if ((m == MODE_RELEASE || m == MODE_TARGET) && tick.tgt_upd && ind_ok && !rel) begin
			m     = MODE_TARGET;
			chime = 1'b1;
		end
		if ((m == MODE_CEILING || m == MODE_TARGET) && tick.tgt_upd && rel)
			m = MODE_RELEASE;

		// supervision rules of the new mode
		case (m)
			MODE_CEILING: begin
				if (tick.train <= tick.limit && s == SUP_NORMAL)
					tone = TONE_NONE;
				if (tick.train > tick.limit && s == SUP_NORMAL) begin
					s    = SUP_OVERSPEED;
					tone = TONE_OVERSPEED;
				end
				if (tick.train > tick.warn && s == SUP_OVERSPEED) begin
					s    = SUP_WARNING;
					tone = TONE_WARNING;
				end
				if (tick.train > tick.ebi && s == SUP_WARNING) begin
					s     = SUP_INTERVENTION;
					brake = 1'b1;
				end
				// revoke the brake only at standstill
				if (tick.train == '0 && s == SUP_INTERVENTION) begin
					s     = SUP_NORMAL;
					brake = 1'b0;
					tone  = TONE_NONE;
				end
				if (tick.train <= tick.limit && s != SUP_INTERVENTION) begin
					s    = SUP_NORMAL;
					tone = TONE_NONE;
				end
			end
			MODE_TARGET: begin
				if (tick.train < tick.ind && s != SUP_INTERVENTION)
					s = SUP_NORMAL;
				if (tick.train >= (tick.ind & FloorMask) && s == SUP_NORMAL)
					s = SUP_INDICATION;
				if (tick.train >= (tick.perm & FloorMask) && s == SUP_INDICATION) begin
					s    = SUP_OVERSPEED;
					tone = TONE_OVERSPEED;
				end
				if (tick.train >= (tick.warn & FloorMask) && s == SUP_OVERSPEED) begin
					s    = SUP_WARNING;
					tone = TONE_WARNING;
				end
				if (tick.train >= (tick.ebi & FloorMask)) begin
					s     = SUP_INTERVENTION;
					brake = 1'b1;
				end
				if (s != SUP_INTERVENTION) begin
					if (tick.train < tick.ind) begin
						s    = SUP_NORMAL;
						tone = TONE_NONE;
					end else if (tick.train <= tick.perm) begin
						s    = SUP_INDICATION;
						tone = TONE_NONE;
					end
				end
			end
			MODE_RELEASE: begin
				tone = TONE_NONE;
				if (tick.train > release_speed) begin
					s     = SUP_INTERVENTION;
					brake = 1'b1;
				end else begin
					s = SUP_INDICATION;
				end
				if (tick.train == '0) begin
					s     = SUP_INDICATION;
					brake = 1'b0;
				end
			end
			default: begin
				// unused mode code: leave status as it is
			end
		endcase

		nxt.mode  = m;
		nxt.sup   = s;
		nxt.brake = brake;
		nxt.tone  = tone;
	end

endmodule

@@ hw/rtl/train_speed_supervision_fsm.sv @@
// Train speed supervision: input register, combinational update step, result register.
// Ticks pass the input register, then the result register. Throughput: 1 tick per cycle
// unless out_stall holds the result; the state fed back through tssf_step sets the rate.
// Reset (arst_n low, asynchronous): ceiling mode, normal status, brake off, no tone,
// release speed 640, both pipeline stages empty.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module train_speed_supervision_fsm
	import tssf_pkg::*;
(
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cfg_wr_en,
	input  logic [SpdW-1:0] cfg_wr_data,
	input  logic           in_valid,
	output logic           in_stall,
	input  logic [SpdW-1:0] train_speed,
	input  logic [SpdW-1:0] limit_speed,
	input  logic [SpdW-1:0] indication_speed,
	input  logic [SpdW-1:0] permitted_speed,
	input  logic [SpdW-1:0] warning_speed,
	input  logic [SpdW-1:0] intervention_speed,
	input  logic           target_update,
	output logic           out_valid,
	input  logic           out_stall,
	output logic [1:0]     mode,
	output logic [2:0]     supervision,
	output logic           emergency_brake,
	output logic [1:0]     tone,
	output logic           mode_chime
);

	speed_t     release_speed_q;
	sup_state_t state_q;
	sup_state_t state_nxt;
	logic       chime_nxt;
	logic       valid_s1;
	tick_t      tick_s1;
	logic       out_valid_q;
	logic       adv;
	logic       res_free;

	// release speed register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			release_speed_q <= ReleaseSpeedRst;
		else if (cfg_wr_en)
			release_speed_q <= cfg_wr_data;
	end

	// handshake: result register frees when empty or taken
	assign res_free = !out_valid_q || !out_stall;
	assign adv      = valid_s1 && res_free;
	assign in_stall = valid_s1 && !res_free;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (!in_stall)
			valid_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			tick_s1.train   <= train_speed;
			tick_s1.limit   <= limit_speed;
			tick_s1.ind     <= indication_speed;
			tick_s1.perm    <= permitted_speed;
			tick_s1.warn    <= warning_speed;
			tick_s1.ebi     <= intervention_speed;
			tick_s1.tgt_upd <= target_update;
		end
	end

	tssf_step u_step (
		.cur           (state_q),
		.tick          (tick_s1),
		.release_speed (release_speed_q),
		.nxt           (state_nxt),
		.chime         (chime_nxt)
	);

	// supervision state: advance once per tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.mode  <= MODE_CEILING;
			state_q.sup   <= SUP_NORMAL;
			state_q.brake <= 1'b0;
			state_q.tone  <= TONE_NONE;
		end else if (adv) begin
			state_q <= state_nxt;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (res_free)
			out_valid_q <= valid_s1;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			mode            <= state_nxt.mode;
			supervision     <= state_nxt.sup;
			emergency_brake <= state_nxt.brake;
			tone            <= state_nxt.tone;
			mode_chime      <= chime_nxt;
		end
	end

	assign out_valid = out_valid_q;

	// intervention always comes with the brake latched
	`ASSERT_IMPLY(a_intv_brake, clk, arst_n,
		out_valid && supervision == SUP_INTERVENTION, emergency_brake)
	// status never takes an unused code
	`ASSERT_IMPLY(a_sup_code, clk, arst_n,
		out_valid, supervision <= SUP_INTERVENTION)
	// release mode silences the alarm
	`ASSERT_IMPLY(a_release_quiet, clk, arst_n,
		out_valid && mode == MODE_RELEASE, tone == TONE_NONE)
	// an empty result register never blocks the input side
	`ASSERT_IMPLY(a_no_false_stall, clk, arst_n, !out_valid_q, !in_stall)

endmodule
